[rtl/hsps_pkg.sv]
// ----------------------------------------------------------------------------
// hsps_pkg
// Shared types for the Annex B SPS parser: item payloads, the request and
// status bundles between the byte front end and the bit-serial decoder.
// ----------------------------------------------------------------------------
package hsps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PROFILE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL   = 3'd3;

    // nal unit types
    localparam logic [4:0] NAL_SPS = 5'd7;
    localparam logic [4:0] NAL_PPS = 5'd8;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pic_width;
        logic [15:0] pic_height;
        logic [7:0]  profile_num;
        logic [7:0]  level_num;
        logic        sps_found;
        logic        pps_found;
        logic        meta_valid;
    } out_item_t;

    typedef enum logic [1:0] {
        DEC_NONE,
        DEC_INIT,
        DEC_FEED,
        DEC_FLUSH
    } dec_op_t;

    typedef struct packed {
        dec_op_t    op;
        logic [7:0] data;
    } dec_req_t;

    typedef struct packed {
        logic        busy;
        logic [15:0] width;
        logic [15:0] height;
    } dec_stat_t;

    typedef struct packed {
        logic       emit;
        logic       sps_seen;
        logic       pps_seen;
        logic [7:0] profile;
        logic [7:0] level;
    } front_stat_t;

endpackage

[rtl/hsps_sps_dec.sv]
// ----------------------------------------------------------------------------
// hsps_sps_dec
// Bit-serial SPS syntax decoder: shifts a payload byte out one bit per cycle
// through the Exp-Golomb reader and the syntax sequencer, or flushes the
// remaining syntax with zero bits at the end of a NAL unit.
// ----------------------------------------------------------------------------
module hsps_sps_dec (
    input  logic                aclk,
    input  logic                aresetn,
    input  hsps_pkg::dec_req_t  req,
    input  logic [7:0]          profile,
    output hsps_pkg::dec_stat_t stat
);

    localparam logic [7:0] HIGH_PROFILE = 8'd100;

    typedef enum logic [4:0] {
        ST_ID, ST_CHROMA, ST_SEP, ST_BDL, ST_BDC, ST_QP, ST_SCALFLAG, ST_SCALSKIP,
        ST_LOG2FN, ST_POCTYPE, ST_LOG2POC, ST_DPOAZ, ST_ONRP, ST_OTTB, ST_NUMCYC,
        ST_CYCLE, ST_MAXREF, ST_GAPS, ST_WIDTH, ST_HEIGHT, ST_FMO, ST_MBAFF,
        ST_D8X8, ST_CROPFLAG, ST_CROPL, ST_CROPR, ST_CROPT, ST_CROPB, ST_DONE
    } step_t;

    step_t       step_reg, step_next;
    logic [5:0]  lzc_reg, lzc_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] loop_reg, loop_next;
    logic        suffix_reg, suffix_next;
    logic        fmo_reg, fmo_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  sh_reg, sh_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        feed_reg, feed_next;
    logic        flush_reg, flush_next;

    logic        bt;
    logic        bit_active;
    logic        cyc_skip;
    logic        use_ue;
    logic        ue_done;
    logic [31:0] ue_vp1;
    logic [31:0] ue_v;
    logic [5:0]  ue_lzc;
    logic [31:0] ue_acc;
    logic        ue_suffix;
    logic [31:0] acc_sh;
    logic [31:0] loop_dec;
    logic [31:0] loop_sum;

    assign bt         = feed_reg ? sh_reg[7] : 1'b0;
    assign bit_active = feed_reg ||
                        (flush_reg && step_reg != ST_DONE && step_reg != ST_CYCLE);
    assign cyc_skip   = !feed_reg && flush_reg && step_reg == ST_CYCLE;
    assign acc_sh     = {acc_reg[30:0], bt};
    assign ue_v       = ue_vp1 - 32'd1;
    assign loop_dec   = loop_reg - 32'd1;
    assign loop_sum   = loop_reg + ue_v;

    // exp-golomb reader, one bit
    always_comb begin
        ue_done   = 1'b0;
        ue_vp1    = '0;
        ue_lzc    = lzc_reg;
        ue_acc    = acc_reg;
        ue_suffix = suffix_reg;
        if (!suffix_reg) begin
            if (!bt) begin
                if (lzc_reg == 6'd31) begin
                    // code capped at 32 zeros, value all ones
                    ue_done = 1'b1;
                    ue_vp1  = '0;
                    ue_lzc  = '0;
                    ue_acc  = '0;
                end else begin
                    ue_lzc = lzc_reg + 6'd1;
                end
            end else if (lzc_reg == 6'd0) begin
                ue_done = 1'b1;
                ue_vp1  = 32'd1;
            end else begin
                ue_suffix = 1'b1;
                ue_acc    = 32'd1;
            end
        end else begin
            ue_lzc = lzc_reg - 6'd1;
            ue_acc = acc_sh;
            if (lzc_reg == 6'd1) begin
                ue_done   = 1'b1;
                ue_vp1    = acc_sh;
                ue_lzc    = '0;
                ue_acc    = '0;
                ue_suffix = 1'b0;
            end
        end
    end

    always_comb begin
        step_next   = step_reg;
        lzc_next    = lzc_reg;
        acc_next    = acc_reg;
        loop_next   = loop_reg;
        suffix_next = suffix_reg;
        fmo_next    = fmo_reg;
        width_next  = width_reg;
        height_next = height_reg;
        sh_next     = sh_reg;
        cnt_next    = cnt_reg;
        feed_next   = feed_reg;
        flush_next  = flush_reg;
        use_ue      = 1'b0;

        if (bit_active) begin
            case (step_reg)
                ST_ID: begin
                    use_ue = 1'b1;
                    if (ue_done) step_next = (profile >= HIGH_PROFILE) ? ST_CHROMA : ST_LOG2FN;
                end
                ST_CHROMA: begin
                    use_ue = 1'b1;
                    if (ue_done) step_next = (ue_vp1 == 32'd4) ? ST_SEP : ST_BDL;
                end
                ST_SEP: step_next = ST_BDL;
                ST_BDL: begin
                    use_ue = 1'b1;
                    if (ue_done) step_next = ST_BDC;
                end
                ST_BDC: begin
                    use_ue = 1'b1;
                    if (ue_done) step_next = ST_QP;
                end
                ST_QP: step_next = ST_SCALFLAG;
                ST_SCALFLAG: begin
                    if (bt) begin
                        loop_next = 32'd8;
                        step_next = ST_SCALSKIP;
                    end else begin
                        step_next = ST_LOG2FN;
                    end
                end
                ST_SCALSKIP: begin
                    loop_next = loop_dec;
                    if (loop_dec == '0) step_next = ST_LOG2FN;
                end
                ST_LOG2FN: begin
                    use_ue = 1'b1;
                    if (ue_done) step_next = ST_POCTYPE;
                end
                ST_POCTYPE: begin
                    use_ue = 1'b1;
                    if (ue_done) begin
                        if (ue_vp1 == 32'd1)      step_next = ST_LOG2POC;
                        else if (ue_vp1 == 32'd2) step_next = ST_DPOAZ;
                        else                      step_next = ST_MAXREF;
                    end
                end
                ST_LOG2POC: begin
                    use_ue = 1'b1;
                    if (ue_done) step_next = ST_MAXREF;
                end
                ST_DPOAZ: step_next = ST_ONRP;
                ST_ONRP: begin
                    use_ue = 1'b1;
                    if (ue_done) step_next = ST_OTTB;
                end
                ST_OTTB: begin
                    use_ue = 1'b1;
                    if (ue_done) step_next = ST_NUMCYC;
                end
                ST_NUMCYC: begin
                    use_ue = 1'b1;
                    if (ue_done) begin
                        loop_next = ue_v;
                        step_next = (ue_vp1 != 32'd1) ? ST_CYCLE : ST_MAXREF;
                    end
                end
                ST_CYCLE: begin
                    use_ue = 1'b1;
                    if (ue_done) begin
                        loop_next = loop_dec;
                        if (loop_dec == '0) step_next = ST_MAXREF;
                    end
                end
                ST_MAXREF: begin
                    use_ue = 1'b1;
                    if (ue_done) step_next = ST_GAPS;
                end
                ST_GAPS: step_next = ST_WIDTH;
                ST_WIDTH: begin
                    use_ue = 1'b1;
                    if (ue_done) begin
                        width_next = {ue_vp1[11:0], 4'b0000};
                        step_next  = ST_HEIGHT;
                    end
                end
                ST_HEIGHT: begin
                    use_ue = 1'b1;
                    if (ue_done) begin
                        height_next = ue_vp1[15:0];
                        step_next   = ST_FMO;
                    end
                end
                ST_FMO: begin
                    fmo_next    = bt;
                    height_next = bt ? {height_reg[11:0], 4'b0000}
                                     : {height_reg[10:0], 5'b00000};
                    step_next   = bt ? ST_D8X8 : ST_MBAFF;
                end
                ST_MBAFF: step_next = ST_D8X8;
                ST_D8X8:  step_next = ST_CROPFLAG;
                ST_CROPFLAG: step_next = bt ? ST_CROPL : ST_DONE;
                ST_CROPL: begin
                    use_ue = 1'b1;
                    if (ue_done) begin
                        loop_next = ue_v;
                        step_next = ST_CROPR;
                    end
                end
                ST_CROPR: begin
                    use_ue = 1'b1;
                    if (ue_done) begin
                        loop_next  = loop_sum;
                        width_next = width_reg - {loop_sum[14:0], 1'b0};
                        step_next  = ST_CROPT;
                    end
                end
                ST_CROPT: begin
                    use_ue = 1'b1;
                    if (ue_done) begin
                        loop_next = ue_v;
                        step_next = ST_CROPB;
                    end
                end
                ST_CROPB: begin
                    use_ue = 1'b1;
                    if (ue_done) begin
                        loop_next   = loop_sum;
                        height_next = height_reg - (fmo_reg ? {loop_sum[14:0], 1'b0}
                                                            : {loop_sum[13:0], 2'b00});
                        step_next   = ST_DONE;
                    end
                end
                default: step_next = ST_DONE;
            endcase
            if (use_ue) begin
                lzc_next    = ue_lzc;
                acc_next    = ue_acc;
                suffix_next = ue_suffix;
            end
        end else if (cyc_skip) begin
            // open ref-frame offset loop ends once the nal runs out
            step_next   = ST_MAXREF;
            lzc_next    = '0;
            acc_next    = '0;
            suffix_next = 1'b0;
        end

        if (feed_reg) begin
            sh_next  = {sh_reg[6:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) feed_next = 1'b0;
        end else if (flush_reg && step_reg == ST_DONE) begin
            flush_next = 1'b0;
        end

        case (req.op)
            hsps_pkg::DEC_INIT: begin
                step_next   = ST_ID;
                lzc_next    = '0;
                acc_next    = '0;
                loop_next   = '0;
                suffix_next = 1'b0;
                fmo_next    = 1'b0;
                width_next  = '0;
                height_next = '0;
                feed_next   = 1'b0;
                flush_next  = 1'b0;
            end
            hsps_pkg::DEC_FEED: begin
                sh_next   = req.data;
                cnt_next  = '0;
                feed_next = 1'b1;
            end
            hsps_pkg::DEC_FLUSH: flush_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= ST_ID;
            lzc_reg    <= '0;
            acc_reg    <= '0;
            loop_reg   <= '0;
            suffix_reg <= 1'b0;
            fmo_reg    <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
            cnt_reg    <= '0;
            feed_reg   <= 1'b0;
            flush_reg  <= 1'b0;
        end else begin
            step_reg   <= step_next;
            lzc_reg    <= lzc_next;
            acc_reg    <= acc_next;
            loop_reg   <= loop_next;
            suffix_reg <= suffix_next;
            fmo_reg    <= fmo_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            cnt_reg    <= cnt_next;
            feed_reg   <= feed_next;
            flush_reg  <= flush_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
    end

    assign stat.busy   = feed_reg || flush_reg;
    assign stat.width  = width_reg;
    assign stat.height = height_reg;

endmodule

[rtl/hsps_front.sv]
// ----------------------------------------------------------------------------
// hsps_front
// Byte front end: start code search, NAL header, emulation prevention,
// SPS payload indexing, and the sequencing of the bit-serial decoder.
// ----------------------------------------------------------------------------
module hsps_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hsps_pkg::in_item_t    s_data,
    input  logic                  out_free,
    input  hsps_pkg::dec_stat_t   dec_stat,
    output hsps_pkg::dec_req_t    dec_req,
    output hsps_pkg::front_stat_t stat
);

    localparam logic [10:0] COUNT_MAX = 11'd2047;

    typedef enum logic [2:0] {
        PH_SEARCH, PH_HEADER, PH_P1, PH_P2, PH_PN
    } phase_t;

    typedef enum logic [2:0] {
        F_IDLE, F_FEED, F_CHK, F_FLUSH, F_EMIT
    } fstate_t;

    fstate_t     state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [23:0] recent_reg, recent_next;
    logic [1:0]  fill_reg, fill_next;
    logic [4:0]  kind_reg, kind_next;
    logic [10:0] pc_reg, pc_next;
    logic [7:0]  profile_reg, profile_next;
    logic [7:0]  level_reg, level_next;
    logic        sps_seen_reg, sps_seen_next;
    logic        pps_seen_reg, pps_seen_next;
    logic        eos_reg, eos_next;
    logic        scf_reg, scf_next;

    logic [7:0] b;
    logic       accept;
    logic       z1, z2, z3;
    logic       sc;
    logic       sps_active;
    logic       drop;
    logic       want_flush;
    logic       emit;

    assign b      = s_data.stream_byte;
    assign accept = s_valid && s_ready;
    assign z1     = fill_reg >= 2'd1 && recent_reg[7:0] == 8'h00;
    assign z2     = fill_reg >= 2'd2 && recent_reg[15:8] == 8'h00;
    assign z3     = fill_reg == 2'd3 && recent_reg[23:16] == 8'h00;
    assign sc     = b == 8'h01 && z1 && z2 && (!s_data.end_of_stream || z3);
    assign sps_active = kind_reg == hsps_pkg::NAL_SPS && !sps_seen_reg &&
                        (phase_reg inside {PH_P1, PH_P2, PH_PN});
    assign drop   = phase_reg == PH_PN && b == 8'h03 && z1 && z2;
    assign want_flush = scf_reg || (eos_reg && sps_active && pc_reg >= 11'd3);
    assign emit   = state_reg == F_EMIT && out_free;
    assign s_ready = state_reg == F_IDLE;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        recent_next   = recent_reg;
        fill_next     = fill_reg;
        kind_next     = kind_reg;
        pc_next       = pc_reg;
        profile_next  = profile_reg;
        level_next    = level_reg;
        sps_seen_next = sps_seen_reg;
        pps_seen_next = pps_seen_reg;
        eos_next      = eos_reg;
        scf_next      = scf_reg;
        dec_req.op    = hsps_pkg::DEC_NONE;
        dec_req.data  = pc_reg[10] ? 8'h00 : b;

        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    eos_next    = s_data.end_of_stream;
                    recent_next = {recent_reg[15:0], b};
                    if (fill_reg != 2'd3) fill_next = fill_reg + 2'd1;
                    state_next  = F_CHK;
                    if (sc) begin
                        // trailing zeros of the code do not count toward the sps
                        scf_next   = sps_active && (z3 ? pc_reg >= 11'd6 : pc_reg >= 11'd5);
                        phase_next = PH_HEADER;
                    end else if (phase_reg == PH_HEADER) begin
                        kind_next = b[4:0];
                        if (b[4:0] == hsps_pkg::NAL_PPS) pps_seen_next = 1'b1;
                        if (b[4:0] == hsps_pkg::NAL_SPS && !sps_seen_reg) begin
                            pc_next      = '0;
                            profile_next = '0;
                            level_next   = '0;
                            dec_req.op   = hsps_pkg::DEC_INIT;
                        end
                        phase_next = PH_P1;
                    end else if (phase_reg inside {PH_P1, PH_P2, PH_PN}) begin
                        if (!drop && sps_active) begin
                            if (pc_reg == 11'd0) begin
                                profile_next = b;
                            end else if (pc_reg == 11'd2) begin
                                level_next = b;
                            end else if (pc_reg >= 11'd3) begin
                                dec_req.op = hsps_pkg::DEC_FEED;
                                state_next = F_FEED;
                            end
                            if (pc_reg != COUNT_MAX) pc_next = pc_reg + 11'd1;
                        end
                        if (phase_reg == PH_P1)      phase_next = PH_P2;
                        else if (phase_reg == PH_P2) phase_next = PH_PN;
                    end
                end
            end
            F_FEED: begin
                if (!dec_stat.busy) state_next = F_CHK;
            end
            F_CHK: begin
                if (want_flush) begin
                    scf_next   = 1'b0;
                    dec_req.op = hsps_pkg::DEC_FLUSH;
                    state_next = F_FLUSH;
                end else if (eos_reg) begin
                    state_next = F_EMIT;
                end else begin
                    state_next = F_IDLE;
                end
            end
            F_FLUSH: begin
                if (!dec_stat.busy) begin
                    sps_seen_next = 1'b1;
                    state_next    = F_CHK;
                end
            end
            F_EMIT: begin
                if (out_free) begin
                    // stream done, back to reset state
                    dec_req.op    = hsps_pkg::DEC_INIT;
                    phase_next    = PH_SEARCH;
                    recent_next   = '0;
                    fill_next     = '0;
                    kind_next     = '0;
                    pc_next       = '0;
                    profile_next  = '0;
                    level_next    = '0;
                    sps_seen_next = 1'b0;
                    pps_seen_next = 1'b0;
                    eos_next      = 1'b0;
                    scf_next      = 1'b0;
                    state_next    = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            phase_reg    <= PH_SEARCH;
            recent_reg   <= '0;
            fill_reg     <= '0;
            kind_reg     <= '0;
            pc_reg       <= '0;
            profile_reg  <= '0;
            level_reg    <= '0;
            sps_seen_reg <= 1'b0;
            pps_seen_reg <= 1'b0;
            eos_reg      <= 1'b0;
            scf_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            recent_reg   <= recent_next;
            fill_reg     <= fill_next;
            kind_reg     <= kind_next;
            pc_reg       <= pc_next;
            profile_reg  <= profile_next;
            level_reg    <= level_next;
            sps_seen_reg <= sps_seen_next;
            pps_seen_reg <= pps_seen_next;
            eos_reg      <= eos_next;
            scf_reg      <= scf_next;
        end
    end

    assign stat.emit     = emit;
    assign stat.sps_seen = sps_seen_reg;
    assign stat.pps_seen = pps_seen_reg;
    assign stat.profile  = profile_reg;
    assign stat.level    = level_reg;

endmodule

[rtl/h264_annexb_sps_parser_unit.sv]
// Takes an H.264 Annex B byte stream, one byte per item, and returns one
// item of SPS metadata (cropped width and height, profile, level, found
// flags and a match flag against the configured values) on the byte marked
// end_of_stream. Each byte passes through the front end's check state
// before the next one is accepted; an SPS payload byte past the first three
// holds the input until the decoder is done with it, since the SPS syntax is
// decoded one bit per cycle by a single Exp-Golomb reader. At the end of an
// SPS NAL unit the rest of the syntax is flushed with zero bits at one bit
// per cycle. The result item sits in an output register while the next
// stream's bytes are accepted.
// ----------------------------------------------------------------------------
// h264_annexb_sps_parser_unit
// Top level: configuration registers, front end, decoder and result register.
// ----------------------------------------------------------------------------
module h264_annexb_sps_parser_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  hsps_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output hsps_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [hsps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hsps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [15:0] exp_width_reg;
    logic [15:0] exp_height_reg;
    logic [7:0]  exp_profile_reg;
    logic [7:0]  exp_level_reg;

    logic                m_valid_reg;
    hsps_pkg::out_item_t m_data_reg;
    hsps_pkg::out_item_t result;

    hsps_pkg::dec_req_t    dec_req;
    hsps_pkg::dec_stat_t   dec_stat;
    hsps_pkg::front_stat_t fstat;
    logic                  out_free;

    assign out_free = !m_valid_reg || m_ready;

    hsps_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .out_free (out_free),
        .dec_stat (dec_stat),
        .dec_req  (dec_req),
        .stat     (fstat)
    );

    hsps_sps_dec u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dec_req),
        .profile (fstat.profile),
        .stat    (dec_stat)
    );

    always_comb begin
        result.sps_found   = fstat.sps_seen;
        result.pps_found   = fstat.pps_seen;
        result.pic_width   = fstat.sps_seen ? dec_stat.width  : 16'h0000;
        result.pic_height  = fstat.sps_seen ? dec_stat.height : 16'h0000;
        result.profile_num = fstat.sps_seen ? fstat.profile   : 8'h00;
        result.level_num   = fstat.sps_seen ? fstat.level     : 8'h00;
        result.meta_valid  = fstat.sps_seen && fstat.pps_seen &&
                             result.pic_width   == exp_width_reg &&
                             result.pic_height  == exp_height_reg &&
                             result.profile_num == exp_profile_reg &&
                             result.level_num   == exp_level_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_width_reg   <= '0;
            exp_height_reg  <= '0;
            exp_profile_reg <= '0;
            exp_level_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hsps_pkg::REG_WIDTH:   exp_width_reg   <= cfg_wdata;
                hsps_pkg::REG_HEIGHT:  exp_height_reg  <= cfg_wdata;
                hsps_pkg::REG_PROFILE: exp_profile_reg <= cfg_wdata[7:0];
                hsps_pkg::REG_LEVEL:   exp_level_reg   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fstat.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fstat.emit) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/hsps_checker.sv]
// ----------------------------------------------------------------------------
// hsps_checker
// Port-level assertions for the SPS parser, bound to the top level.
// ----------------------------------------------------------------------------
module hsps_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input hsps_pkg::in_item_t               s_data,
    input logic                             m_valid,
    input logic                             m_ready,
    input hsps_pkg::out_item_t              m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // the final byte of a stream is never followed at once by another item
    a_eos_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.end_of_stream |=> !s_ready)
        else $error("item taken right after end of stream");

    a_valid_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.meta_valid |-> m_data.sps_found && m_data.pps_found)
        else $error("meta_valid without sps and pps");

    a_no_sps_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.sps_found |-> m_data.pic_width == 16'h0000 &&
            m_data.pic_height == 16'h0000 && m_data.profile_num == 8'h00 &&
            m_data.level_num == 8'h00)
        else $error("metadata reported without an sps");

endmodule

bind h264_annexb_sps_parser_unit hsps_checker u_hsps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
